@@ hdl/adpcm_block_encoder_search_unit_defines.svh @@
// Assertion macros shared by the ADPCM block encoder search unit.
`ifndef ADPCM_BLOCK_ENCODER_SEARCH_UNIT_DEFINES_SVH
`define ADPCM_BLOCK_ENCODER_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adpcm encoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ABE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adpcm encoder: next-cycle check failed");

`endif

@@ hdl/abe_pkg.sv @@
// Package: types, constants and coefficient tables of the ADPCM block encoder.
`default_nettype none
package abe_pkg;

    localparam int SAMPLES_PER_BLOCK = 28;
    localparam int SAMPLE_W          = 16;
    localparam int Q_W               = 28;   // Q16.12 history / sample
    localparam int PRED_W            = 30;   // rounded prediction
    localparam int ERR_W             = 61;   // summed squared error
    localparam int IDX_W             = 5;    // sample index
    localparam int NIB_BYTES         = 14;
    localparam int NB_W              = 4;    // nibble byte index / output byte index
    localparam int FILTER_COUNT      = 5;
    localparam int MAX_SHIFT         = 12;
    localparam int PEAK_W            = 31;

    localparam logic [IDX_W-1:0] LAST_SAMPLE = IDX_W'(SAMPLES_PER_BLOCK - 1);
    localparam logic [2:0] LAST_FILTER = 3'(FILTER_COUNT - 1);
    localparam logic [NB_W-1:0] LAST_BYTE = 4'd15;

    // Register indexes of the configuration port
    localparam logic REG_FLAGS_BYTE   = 1'b0;
    localparam logic REG_SHIFT_WINDOW = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic collect;
        logic start;
        logic peak_init;
        logic pred;
        logic peak_step;
        logic set_ideal;
        logic trial_init;
        logic trial_step;
        logic judge;
        logic finish;
        logic emit_next;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_last;
        logic peak_last;
        logic trial_last;
        logic shift_last;
        logic filter_last;
        logic win;
        logic early;
        logic byte_last;
    } status_t;

    // Predictor coefficients in 1/64 units
    function automatic logic signed [7:0] coef_a(input logic [2:0] f);
        logic signed [7:0] c;
        case (f)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [7:0] coef_b(input logic [2:0] f);
        logic signed [7:0] c;
        case (f)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/abe_datapath.sv @@
// Datapath: sample store, channel history, predictor, quantizer, error sum, best tracking.
`default_nettype none
module abe_datapath #(
    parameter int CHANNEL_COUNT = 2,
    parameter int PEAK_WINDOW   = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire abe_pkg::cmd_t                      cmd,
    output abe_pkg::status_t                        status,
    input  wire logic signed [abe_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                               channel,
    input  wire logic                               new_stream,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [7:0]                         cfg_data,
    output logic [7:0]                              block_byte,
    output logic                                    last_byte
);

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [abe_pkg::IDX_W-1:0] PEAK_LAST_IDX = abe_pkg::IDX_W'(PEAK_WINDOW - 1);

    // configuration
    logic [7:0] flags_reg;
    logic [3:0] window_reg;

    // collection
    logic signed [abe_pkg::SAMPLE_W-1:0] sample_mem [abe_pkg::SAMPLES_PER_BLOCK];
    logic [abe_pkg::IDX_W-1:0] fill_reg;
    logic [CH_W-1:0] chan_reg;
    logic [CH_W-1:0] in_chan;
    logic signed [abe_pkg::Q_W-1:0] hist_recent_reg [CHANNEL_COUNT];
    logic signed [abe_pkg::Q_W-1:0] hist_older_reg [CHANNEL_COUNT];

    // search working state
    logic signed [abe_pkg::Q_W-1:0] h1_reg, h2_reg, base_h1_reg, base_h2_reg;
    logic signed [abe_pkg::PRED_W-1:0] pred_reg;
    logic [abe_pkg::IDX_W-1:0] idx_reg;
    logic [2:0] filter_reg;
    logic [3:0] shift_reg, hi_reg;
    logic [abe_pkg::PEAK_W-1:0] peak_reg;
    logic [abe_pkg::Q_W-1:0] emag_reg;
    logic sq_valid_reg;
    logic [abe_pkg::ERR_W-1:0] acc_reg, best_err_reg;
    logic [6:0] best_fs_reg;
    logic signed [abe_pkg::Q_W-1:0] best_h1_reg, best_h2_reg;
    logic best_bank_reg;
    logic [7:0] nib_mem [2][abe_pkg::NIB_BYTES];
    logic [abe_pkg::NB_W-1:0] out_idx_reg;

    // combinational
    logic signed [abe_pkg::SAMPLE_W-1:0] smp_rd;
    logic signed [abe_pkg::Q_W-1:0] s12;
    logic signed [35:0] q18;
    logic signed [abe_pkg::PRED_W-1:0] pred_next;
    logic signed [31:0] d;
    logic [31:0] mag;
    logic [4:0] step_bits;
    logic [32:0] half, qsum, q;
    logic [3:0] qc;
    logic signed [3:0] nib;
    logic signed [32:0] rec, rec_c;
    logic signed [abe_pkg::Q_W-1:0] rec_q;
    logic signed [abe_pkg::Q_W:0] e;
    logic [abe_pkg::Q_W-1:0] emag;
    logic [2*abe_pkg::Q_W-1:0] sq;
    logic [3:0] kcnt, ideal, lo_sel, hi_sel;
    logic [4:0] hi_sum;
    logic [abe_pkg::NB_W-1:0] byte_sel;
    logic [7:0] byte_val;

    assign in_chan = (CHANNEL_COUNT > 1) ? CH_W'(channel) : '0;
    assign smp_rd  = sample_mem[idx_reg];
    assign s12     = {smp_rd, 12'b0};
    assign sq      = emag_reg * emag_reg;

    // prediction, rounded from Q.18 to Q.12 with half up
    always_comb
    begin
        q18 = h1_reg * abe_pkg::coef_a(filter_reg) + h2_reg * abe_pkg::coef_b(filter_reg)
            + 36'sd32;
        pred_next = abe_pkg::PRED_W'(q18 >>> 6);
    end

    // quantize, reconstruct, error
    always_comb
    begin
        d = 32'(s12) - 32'(pred_reg);
        mag = d[31] ? 32'(-d) : 32'(d);
        step_bits = 5'd24 - 5'(shift_reg);
        half = 33'd1 << (step_bits - 5'd1);
        qsum = 33'(mag) + half;
        q = qsum >> step_bits;
        if (d[31])
        begin
            qc = (q > 33'd8) ? 4'd8 : q[3:0];
            nib = 4'(-$signed(qc));
        end
        else
        begin
            qc = (q > 33'd7) ? 4'd7 : q[3:0];
            nib = $signed(qc);
        end
        rec = (33'(nib) <<< step_bits) + 33'(pred_reg);
        if (rec > 33'sd134213632)
            rec_c = 33'sd134213632;
        else if (rec < -33'sd134217728)
            rec_c = -33'sd134217728;
        else
            rec_c = rec;
        rec_q = abe_pkg::Q_W'(rec_c);
        e = (abe_pkg::Q_W+1)'(s12) - (abe_pkg::Q_W+1)'(rec_q);
        emag = e[abe_pkg::Q_W] ? abe_pkg::Q_W'(-e) : abe_pkg::Q_W'(e);
    end

    // ideal shift from peak error: count thresholds 28672 << (t+1) reached
    always_comb
    begin
        kcnt = 4'd0;
        for (int t = 0; t <= abe_pkg::MAX_SHIFT; t++)
        begin
            if (peak_reg >= (abe_pkg::PEAK_W'(28672) << (t + 1)))
                kcnt = kcnt + 4'd1;
        end
        ideal = (kcnt >= 4'd12) ? 4'd0 : 4'd12 - kcnt;
        lo_sel = (ideal >= window_reg) ? ideal - window_reg : 4'd0;
        hi_sum = 5'(ideal) + 5'(window_reg);
        hi_sel = (hi_sum > 5'd12) ? 4'd12 : hi_sum[3:0];
    end

    // output byte selection
    always_comb
    begin
        byte_sel = cmd.finish ? '0 : out_idx_reg + 4'd1;
        case (byte_sel)
            4'd0:    byte_val = {1'b0, best_fs_reg};
            4'd1:    byte_val = flags_reg;
            default: byte_val = nib_mem[best_bank_reg][byte_sel - 4'd2];
        endcase
    end

    // status
    always_comb
    begin
        status.fill_last   = (fill_reg == abe_pkg::LAST_SAMPLE);
        status.peak_last   = (idx_reg == PEAK_LAST_IDX);
        status.trial_last  = (idx_reg == abe_pkg::LAST_SAMPLE);
        status.shift_last  = (shift_reg == hi_reg);
        status.filter_last = (filter_reg == abe_pkg::LAST_FILTER);
        status.win         = (acc_reg < best_err_reg);
        status.early       = (acc_reg < abe_pkg::ERR_W'(1 << 24));
        status.byte_last   = (out_idx_reg == abe_pkg::LAST_BYTE);
    end

    // control-side registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= 8'd2;
            window_reg    <= 4'd2;
            fill_reg      <= '0;
            chan_reg      <= '0;
            best_err_reg  <= '1;
            best_fs_reg   <= '0;
            best_h1_reg   <= '0;
            best_h2_reg   <= '0;
            best_bank_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                hist_recent_reg[c] <= '0;
                hist_older_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == abe_pkg::REG_FLAGS_BYTE)
                    flags_reg <= cfg_data;
                else
                    window_reg <= cfg_data[3:0];
            end
            sq_valid_reg <= cmd.trial_step;
            if (cmd.collect)
            begin
                fill_reg <= status.fill_last ? '0 : fill_reg + 5'd1;
                if (fill_reg == '0)
                begin
                    chan_reg <= in_chan;
                    if (new_stream)
                    begin
                        hist_recent_reg[in_chan] <= '0;
                        hist_older_reg[in_chan]  <= '0;
                    end
                end
            end
            if (cmd.start)
            begin
                best_err_reg <= '1;
                best_fs_reg  <= '0;
                best_h1_reg  <= hist_recent_reg[chan_reg];
                best_h2_reg  <= hist_older_reg[chan_reg];
            end
            if (cmd.judge && status.win)
            begin
                best_err_reg  <= acc_reg;
                best_fs_reg   <= {filter_reg, shift_reg};
                best_h1_reg   <= h1_reg;
                best_h2_reg   <= h2_reg;
                best_bank_reg <= ~best_bank_reg;
            end
            if (cmd.finish)
            begin
                hist_recent_reg[chan_reg] <= best_h1_reg;
                hist_older_reg[chan_reg]  <= best_h2_reg;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.collect)
            sample_mem[fill_reg] <= sample;
        if (cmd.start)
        begin
            base_h1_reg <= hist_recent_reg[chan_reg];
            base_h2_reg <= hist_older_reg[chan_reg];
            filter_reg  <= '0;
        end
        if (cmd.peak_init || cmd.trial_init)
        begin
            h1_reg  <= base_h1_reg;
            h2_reg  <= base_h2_reg;
            idx_reg <= '0;
        end
        if (cmd.peak_init)
            peak_reg <= '0;
        if (cmd.trial_init)
            acc_reg <= '0;
        if (cmd.pred)
            pred_reg <= pred_next;
        if (cmd.peak_step)
        begin
            if (abe_pkg::PEAK_W'(mag) > peak_reg)
                peak_reg <= abe_pkg::PEAK_W'(mag);
            h2_reg  <= h1_reg;
            h1_reg  <= s12;
            idx_reg <= idx_reg + 5'd1;
        end
        if (cmd.set_ideal)
        begin
            shift_reg <= lo_sel;
            hi_reg    <= hi_sel;
        end
        if (cmd.trial_step)
        begin
            if (idx_reg[0])
                nib_mem[~best_bank_reg][idx_reg[4:1]][7:4] <= nib;
            else
                nib_mem[~best_bank_reg][idx_reg[4:1]][3:0] <= nib;
            h2_reg   <= h1_reg;
            h1_reg   <= rec_q;
            emag_reg <= emag;
            idx_reg  <= idx_reg + 5'd1;
        end
        if (sq_valid_reg)
            acc_reg <= acc_reg + abe_pkg::ERR_W'(sq);
        if (cmd.judge && !(status.win && status.early))
        begin
            if (status.shift_last)
                filter_reg <= filter_reg + 3'd1;
            else
                shift_reg <= shift_reg + 4'd1;
        end
        if (cmd.finish || cmd.emit_next)
        begin
            out_idx_reg <= byte_sel;
            block_byte  <= byte_val;
            last_byte   <= (byte_sel == abe_pkg::LAST_BYTE);
        end
    end

endmodule
`default_nettype wire

@@ hdl/abe_controller.sv @@
// Controller: state machine sequencing collection, peak pass, trials and output.
`default_nettype none
module abe_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire abe_pkg::status_t  status,
    output abe_pkg::cmd_t          cmd
);

    typedef enum logic [12:0] {
        S_COLLECT    = 13'b0000000000001,
        S_START      = 13'b0000000000010,
        S_PEAK_INIT  = 13'b0000000000100,
        S_PEAK_PRED  = 13'b0000000001000,
        S_PEAK_STEP  = 13'b0000000010000,
        S_IDEAL      = 13'b0000000100000,
        S_TRIAL_INIT = 13'b0000001000000,
        S_TRIAL_PRED = 13'b0000010000000,
        S_TRIAL_STEP = 13'b0000100000000,
        S_DRAIN      = 13'b0001000000000,
        S_JUDGE      = 13'b0010000000000,
        S_FINISH     = 13'b0100000000000,
        S_EMIT       = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic accept;

    // samples are taken while collecting or emitting; the closing one waits until the last byte leaves
    assign in_stall  = !((state_reg == S_COLLECT) || (state_reg == S_EMIT))
                     || ((state_reg == S_EMIT) && status.fill_last);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_EMIT);

    always_comb
    begin
        cmd = '0;
        cmd.collect = accept;
        state_next = state_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (accept && status.fill_last)
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.start = 1'b1;
                state_next = S_PEAK_INIT;
            end
            S_PEAK_INIT:
            begin
                cmd.peak_init = 1'b1;
                state_next = S_PEAK_PRED;
            end
            S_PEAK_PRED:
            begin
                cmd.pred = 1'b1;
                state_next = S_PEAK_STEP;
            end
            S_PEAK_STEP:
            begin
                cmd.peak_step = 1'b1;
                state_next = status.peak_last ? S_IDEAL : S_PEAK_PRED;
            end
            S_IDEAL:
            begin
                cmd.set_ideal = 1'b1;
                state_next = S_TRIAL_INIT;
            end
            S_TRIAL_INIT:
            begin
                cmd.trial_init = 1'b1;
                state_next = S_TRIAL_PRED;
            end
            S_TRIAL_PRED:
            begin
                cmd.pred = 1'b1;
                state_next = S_TRIAL_STEP;
            end
            S_TRIAL_STEP:
            begin
                cmd.trial_step = 1'b1;
                state_next = status.trial_last ? S_DRAIN : S_TRIAL_PRED;
            end
            S_DRAIN:
            begin
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                cmd.judge = 1'b1;
                if (status.win && status.early)
                    state_next = S_FINISH;
                else if (!status.shift_last)
                    state_next = S_TRIAL_INIT;
                else if (status.filter_last)
                    state_next = S_FINISH;
                else
                    state_next = S_PEAK_INIT;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    if (status.byte_last)
                        state_next = S_COLLECT;
                    else
                        cmd.emit_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_COLLECT;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

@@ hdl/adpcm_block_encoder_search_unit.sv @@
// Top level: ADPCM block encoder with filter/shift search.
//
// Input channel (in_valid/in_stall): one signed 16-bit sample per request with
// channel and new_stream, both taken from the first sample of a block only.
// Every 28th sample closes a block and starts the search. Output channel
// (out_valid/out_stall): 16 byte requests per block, header byte
// (filter << 4 | shift), flags byte, then 14 bytes of nibbles low half first;
// last_byte marks byte 15.
// The search runs one shared predictor/quantizer over a peak pass and the
// trials of each filter; trials range from 1 to 5*min(2*shift_window+1, 13),
// fewer on an early exit. No samples are taken during the search.
// While the block is emitted the next samples are taken, except the closing
// one, which waits until the last byte leaves. A stalled receiver holds the
// current byte. Reset clears channel histories, the fill count and the state
// machine and sets flags_byte and shift_window to 2.
`default_nettype none
module adpcm_block_encoder_search_unit #(
    parameter int CHANNEL_COUNT = 2,
    parameter int PEAK_WINDOW   = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [abe_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                channel,
    input  wire logic                                new_stream,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [7:0]                               block_byte,
    output logic                                     last_byte,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [7:0]                          cfg_data
);

    abe_pkg::cmd_t    cmd;
    abe_pkg::status_t status;

    abe_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    abe_datapath #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .PEAK_WINDOW   (PEAK_WINDOW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample     (sample),
        .channel    (channel),
        .new_stream (new_stream),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .block_byte (block_byte),
        .last_byte  (last_byte)
    );

`include "adpcm_block_encoder_search_unit_defines.svh"

    // closing sample of a block starts the search at once
    `ABE_ASSERT_NEXT(a_close_starts, clk, rst_n, in_valid && !in_stall && status.fill_last, in_stall)
    // bytes of one block leave without gaps
    `ABE_ASSERT_NEXT(a_bytes_back_to_back, clk, rst_n, out_valid && !out_stall && !last_byte, out_valid)
    // no trial work while a block is being emitted
    `ABE_ASSERT_SAME(a_no_search_in_emit, clk, rst_n, out_valid, !cmd.trial_step && !cmd.judge)

endmodule
`default_nettype wire
